[hw/rtl/sdm2_pkg.sv]
package sdm2_pkg;

  // Field and register widths
  localparam int unsigned SampleW = 16;
  localparam int unsigned ClampW  = 13;
  localparam int unsigned GainW   = 16;
  localparam int unsigned IntW    = 16;
  localparam int unsigned CfgIdxW = 2;

  // Register reset values
  localparam logic [GainW-1:0] GainInFbFirstRst    = 16'd51138;
  localparam logic [GainW-1:0] GainBetweenStagesRst = 16'd3493;
  localparam logic [GainW-1:0] GainFbSecondRst     = 16'd9765;

  // Sample clamp limits (13-bit signed)
  localparam logic signed [SampleW-1:0] SampleMax = 16'sd4095;
  localparam logic signed [SampleW-1:0] SampleMin = -16'sd4096;

  // Integrator saturation limits
  localparam logic signed [17:0] Int1Max = 18'sd32767;
  localparam logic signed [17:0] Int1Min = -18'sd32768;
  localparam logic signed [17:0] Int2Max = 18'sd16383;
  localparam logic signed [17:0] Int2Min = -18'sd16384;

  // Configuration register indexes
  typedef enum logic [CfgIdxW-1:0] {
    CFG_GAIN_IN_FB_FIRST    = 2'd0,
    CFG_GAIN_BETWEEN_STAGES = 2'd1,
    CFG_GAIN_FB_SECOND      = 2'd2
  } cfg_idx_t;

  // Controller states
  typedef enum logic [1:0] {
    ST_IDLE  = 2'd0,
    ST_STEP1 = 2'd1,
    ST_STEP2 = 2'd2
  } sdm2_state_t;

  // Commands from controller to datapath
  typedef struct packed {
    logic accept;  // item taken this cycle
    logic update;  // item advances the loop
    logic step1;   // update first integrator
    logic step2;   // update second integrator
  } sdm2_cmd_t;

endpackage

[hw/rtl/sdm2_ctrl.sv]
module sdm2_ctrl (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  input  logic                 in_update,
  output logic                 in_stall,
  output logic                 out_valid,
  input  logic                 out_stall,
  output sdm2_pkg::sdm2_cmd_t  cmd
);

  sdm2_pkg::sdm2_state_t state_r, state_nxt;
  logic                  out_valid_r, out_valid_nxt;
  logic                  accept;

  // Take an item only when idle and the output slot is free or draining
  assign accept    = in_valid && (state_r == sdm2_pkg::ST_IDLE) &&
                     (!out_valid_r || !out_stall);
  assign in_stall  = !((state_r == sdm2_pkg::ST_IDLE) && (!out_valid_r || !out_stall));
  assign out_valid = out_valid_r;

  // State and output-valid registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= sdm2_pkg::ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Next state and commands
  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = accept ? 1'b1 : (out_valid_r && out_stall);
    cmd.accept    = accept;
    cmd.update    = in_update;
    cmd.step1     = 1'b0;
    cmd.step2     = 1'b0;
    unique case (state_r)
      sdm2_pkg::ST_IDLE: begin
        if (accept && in_update) state_nxt = sdm2_pkg::ST_STEP1;
      end
      sdm2_pkg::ST_STEP1: begin
        cmd.step1 = 1'b1;
        state_nxt = sdm2_pkg::ST_STEP2;
      end
      sdm2_pkg::ST_STEP2: begin
        cmd.step2 = 1'b1;
        state_nxt = sdm2_pkg::ST_IDLE;
      end
      default: state_nxt = sdm2_pkg::ST_IDLE;
    endcase
  end

  // First step only right after an accepted update item
  a_step1_after_update: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.step1 |-> $past(accept && in_update))
    else $error("step1 without accepted update item");

  // Second step always follows the first
  a_step2_after_step1: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.step1 |=> cmd.step2)
    else $error("step2 did not follow step1");

  // No item is taken while the integrators are busy
  a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.step1 || cmd.step2) |-> in_stall)
    else $error("input open during integrator update");

  // Accepting always leaves a result pending
  a_accept_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> out_valid_r)
    else $error("accepted item produced no result");

endmodule

[hw/rtl/sdm2_dp.sv]
module sdm2_dp (
  input  logic                              clk,
  input  logic                              rst_n,
  input  sdm2_pkg::sdm2_cmd_t               cmd,
  input  logic signed [sdm2_pkg::SampleW-1:0] in_sample,
  input  logic                              cfg_we,
  input  logic [sdm2_pkg::CfgIdxW-1:0]      cfg_index,
  input  logic [sdm2_pkg::GainW-1:0]        cfg_data,
  output logic                              out_pdm_bit
);

  logic [sdm2_pkg::GainW-1:0]         gain1_r, gain2_r, gain3_r;
  logic signed [sdm2_pkg::IntW-1:0]   int1_r, int1_nxt;
  logic signed [sdm2_pkg::IntW-1:0]   int2_r, int2_nxt;
  logic                               held_bit_r;
  logic                               pdm_bit_r;
  logic signed [sdm2_pkg::ClampW-1:0] sample_r, sample_nxt;
  logic                               new_bit;

  logic signed [29:0] prod1;
  logic signed [13:0] b1u;
  logic signed [17:0] g1_fb;
  logic signed [13:0] a1fb;
  logic signed [17:0] acc1;
  logic signed [32:0] prod2;
  logic signed [15:0] c1x;
  logic signed [17:0] g3_fb;
  logic signed [12:0] a2fb;
  logic signed [17:0] acc2;

  // Quantizer: sign of second integrator before the update
  assign new_bit = !int2_r[sdm2_pkg::IntW-1];

  // Clamp the sample to 13-bit signed
  always_comb begin
    if (in_sample > sdm2_pkg::SampleMax)      sample_nxt = sdm2_pkg::SampleMax[12:0];
    else if (in_sample < sdm2_pkg::SampleMin) sample_nxt = sdm2_pkg::SampleMin[12:0];
    else                                      sample_nxt = in_sample[12:0];
  end

  // First integrator: int1 + B1*u - B1*fb, floor products, saturate
  always_comb begin
    prod1 = $signed({1'b0, gain1_r}) * sample_r;
    b1u   = prod1[29:16];
    g1_fb = held_bit_r ? $signed({2'b00, gain1_r}) : -$signed({2'b00, gain1_r});
    a1fb  = g1_fb[17:4];
    acc1  = {{2{int1_r[15]}}, int1_r} + {{4{b1u[13]}}, b1u} - {{4{a1fb[13]}}, a1fb};
    if (acc1 > sdm2_pkg::Int1Max)      int1_nxt = sdm2_pkg::Int1Max[15:0];
    else if (acc1 < sdm2_pkg::Int1Min) int1_nxt = sdm2_pkg::Int1Min[15:0];
    else                               int1_nxt = acc1[15:0];
  end

  // Second integrator: int2 + C1*int1 - A2*fb, floor products, saturate
  always_comb begin
    prod2 = $signed({1'b0, gain2_r}) * int1_r;
    c1x   = prod2[32:17];
    g3_fb = held_bit_r ? $signed({2'b00, gain3_r}) : -$signed({2'b00, gain3_r});
    a2fb  = g3_fb[17:5];
    acc2  = {{2{int2_r[15]}}, int2_r} + {{2{c1x[15]}}, c1x} - {{5{a2fb[12]}}, a2fb};
    if (acc2 > sdm2_pkg::Int2Max)      int2_nxt = sdm2_pkg::Int2Max[15:0];
    else if (acc2 < sdm2_pkg::Int2Min) int2_nxt = sdm2_pkg::Int2Min[15:0];
    else                               int2_nxt = acc2[15:0];
  end

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gain1_r <= sdm2_pkg::GainInFbFirstRst;
      gain2_r <= sdm2_pkg::GainBetweenStagesRst;
      gain3_r <= sdm2_pkg::GainFbSecondRst;
    end else if (cfg_we) begin
      unique case (cfg_index)
        sdm2_pkg::CFG_GAIN_IN_FB_FIRST:    gain1_r <= cfg_data;
        sdm2_pkg::CFG_GAIN_BETWEEN_STAGES: gain2_r <= cfg_data;
        sdm2_pkg::CFG_GAIN_FB_SECOND:      gain3_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // Loop state and output bit
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      int1_r     <= '0;
      int2_r     <= '0;
      held_bit_r <= 1'b0;
      pdm_bit_r  <= 1'b0;
    end else begin
      if (cmd.accept) begin
        pdm_bit_r <= cmd.update ? new_bit : held_bit_r;
        if (cmd.update) held_bit_r <= new_bit;
      end
      if (cmd.step1) int1_r <= int1_nxt;
      if (cmd.step2) int2_r <= int2_nxt;
    end
  end

  // Sample capture
  always_ff @(posedge clk) begin
    if (cmd.accept && cmd.update) sample_r <= sample_nxt;
  end

  assign out_pdm_bit = pdm_bit_r;

  // Second integrator stays inside its saturation range
  a_int2_range: assert property (@(posedge clk) disable iff (!rst_n)
    (int2_r <= 16'sd16383) && (int2_r >= -16'sd16384))
    else $error("second integrator out of range");

  // Held bit moves only on an accepted update item
  a_held_bit_stable: assert property (@(posedge clk) disable iff (!rst_n)
    !(cmd.accept && cmd.update) |=> $stable(held_bit_r))
    else $error("held bit changed without update");

  // Integrators stay put outside their steps
  a_int_stable: assert property (@(posedge clk) disable iff (!rst_n)
    !(cmd.step1 || cmd.step2) |=> ($stable(int1_r) && $stable(int2_r)))
    else $error("integrator changed outside its step");

endmodule

[hw/rtl/sigma_delta_modulator_cifb2.sv]
// The pdm bit of an item is registered on acceptance and offered the cycle after.
// An update item takes three steps (accept, first and second integrator step,
// each integrator step through its own multiply-add-saturate path) and the
// input stalls until both are done; a hold item is only accepted.
// Reset (rst_n low, synchronous): integrators and held bit cleared, gains set to
// 51138 / 3493 / 9765, no result pending.
module sigma_delta_modulator_cifb2 (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic signed [sdm2_pkg::SampleW-1:0] in_sample,
  input  logic                                in_update,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic                                out_pdm_bit,
  input  logic                                cfg_we,
  input  logic [sdm2_pkg::CfgIdxW-1:0]        cfg_index,
  input  logic [sdm2_pkg::GainW-1:0]          cfg_data
);

  sdm2_pkg::sdm2_cmd_t cmd;

  // Sequencer
  sdm2_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_update (in_update),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cmd       (cmd)
  );

  // Integrators, gains and output bit
  sdm2_dp u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .cmd         (cmd),
    .in_sample   (in_sample),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .out_pdm_bit (out_pdm_bit)
  );

endmodule
